@@ hdl/dhot_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package dhot_pkg;

  localparam int OP_W       = 2;
  localparam int KEY_PORT_W = 32;
  localparam int HASH_W     = 32;
  localparam int CFG_W      = 8;
  localparam int STATUS_W   = 3;
  localparam int SLOT_W     = 7;
  localparam int COUNT_W    = 8;
  localparam int DIV_CNT_W  = $clog2(HASH_W + 1);

  localparam logic [CFG_W-1:0] CFG_SLOTS_RESET = 8'd127;

  typedef logic [OP_W-1:0]     op_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam op_t OP_INSERT = 2'd0;
  localparam op_t OP_LOOKUP = 2'd1;
  localparam op_t OP_REMOVE = 2'd2;

  localparam status_t ST_INSERTED  = 3'd0;
  localparam status_t ST_EXISTS    = 3'd1;
  localparam status_t ST_FULL      = 3'd2;
  localparam status_t ST_FOUND     = 3'd3;
  localparam status_t ST_NOT_FOUND = 3'd4;
  localparam status_t ST_REMOVED   = 3'd5;

  typedef struct packed {
    logic    clr_step;
    logic    load;
    logic    div_step;
    logic    scan_start;
    logic    scan_free;
    logic    scan_step;
    logic    res_load;
    status_t res_status;
    logic    res_slot_en;
    logic    wr_insert;
    logic    wr_remove;
  } dhot_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic div_done;
    logic scan_done;
    logic hit;
    logic op_insert;
    logic op_remove;
  } dhot_stat_t;

endpackage

`default_nettype wire

@@ hdl/dhot_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none

module dhot_dp
  import dhot_pkg::*;
#(
  parameter int MAX_SLOTS = 128,
  parameter int KEY_WIDTH = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_W-1:0]      cfg_wr_data,
  input  wire logic [OP_W-1:0]       in_op,
  input  wire logic [KEY_PORT_W-1:0] in_key,
  input  wire logic [HASH_W-1:0]     in_hash_primary,
  input  wire logic [HASH_W-1:0]     in_hash_secondary,
  input  wire dhot_cmd_t             cmd,
  output dhot_stat_t                 st,
  output logic [STATUS_W-1:0]        out_status,
  output logic [SLOT_W-1:0]          out_slot_index,
  output logic [COUNT_W-1:0]         out_entry_count,
  output logic                       out_resize_needed
);

  localparam int IW = $clog2(MAX_SLOTS);
  localparam int NW = IW + 1;
  localparam int KW = (KEY_WIDTH < KEY_PORT_W) ? KEY_WIDTH : KEY_PORT_W;
  localparam int EW = KW + 1;

  logic [EW-1:0]        mem [MAX_SLOTS];
  logic [EW-1:0]        rdq_r;

  logic [CFG_W-1:0]     slots_in_use_r;
  logic [IW-1:0]        clr_r;
  logic [NW-1:0]        n_r;
  logic [NW-1:0]        n_eff;
  op_t                  op_r;
  logic [KW-1:0]        key_r;
  logic [HASH_W-1:0]    ha_r;
  logic [HASH_W-1:0]    hb_r;
  logic [NW-1:0]        rem_a_r;
  logic [NW-1:0]        rem_b_r;
  logic [NW-1:0]        rem_a_nxt;
  logic [NW-1:0]        rem_b_nxt;
  logic [NW:0]          ta;
  logic [NW:0]          tb;
  logic [DIV_CNT_W-1:0] div_cnt_r;

  logic [IW-1:0]        idx_r;
  logic [IW-1:0]        idx_nxt;
  logic [IW:0]          idx_sum;
  logic [IW-1:0]        step_r;
  logic [NW-1:0]        cnt_r;
  logic                 pv_r;
  logic [IW-1:0]        pidx_r;
  logic                 hit_r;
  logic [IW-1:0]        where_r;
  logic                 issue;
  logic                 match;

  logic [NW-1:0]        occ_r;
  logic [NW-1:0]        occ_nxt;
  logic [NW-1:0]        free_slots;

  logic                 mem_we;
  logic [IW-1:0]        mem_waddr;
  logic [EW-1:0]        mem_wdata;

  status_t              status_r;
  logic [SLOT_W-1:0]    slot_r;
  logic [COUNT_W-1:0]   count_r;
  logic                 resize_r;

  // effective table size
  always_comb begin
    if (slots_in_use_r == '0) begin
      n_eff = NW'(1);
    end else if (32'(slots_in_use_r) > MAX_SLOTS) begin
      n_eff = NW'(MAX_SLOTS);
    end else begin
      n_eff = NW'(slots_in_use_r);
    end
  end

  // one restoring remainder step for each hash
  always_comb begin
    ta = {rem_a_r, ha_r[HASH_W-1]};
    tb = {rem_b_r, hb_r[HASH_W-1]};
    rem_a_nxt = (ta >= {1'b0, n_r}) ? NW'(ta - {1'b0, n_r}) : NW'(ta);
    rem_b_nxt = (tb >= {1'b0, n_r}) ? NW'(tb - {1'b0, n_r}) : NW'(tb);
  end

  // probe advance, kept below n
  always_comb begin
    idx_sum = {1'b0, idx_r} + {1'b0, step_r};
    if ({1'b0, idx_sum} >= {1'b0, n_r}) begin
      idx_nxt = IW'({1'b0, idx_sum} - {1'b0, n_r});
    end else begin
      idx_nxt = IW'(idx_sum);
    end
  end

  assign issue = cmd.scan_step && !hit_r && (cnt_r != n_r);
  assign match = pv_r && !hit_r &&
                 (cmd.scan_free ? !rdq_r[KW] : (rdq_r[KW] && (rdq_r[KW-1:0] == key_r)));

  always_comb begin
    occ_nxt = occ_r;
    if (cmd.wr_insert) begin
      occ_nxt = occ_r + NW'(1);
    end else if (cmd.wr_remove) begin
      occ_nxt = occ_r - NW'(1);
    end
    free_slots = (n_r > occ_nxt) ? (n_r - occ_nxt) : '0;
  end

  always_comb begin
    mem_we    = cmd.clr_step || (cmd.res_load && (cmd.wr_insert || cmd.wr_remove));
    mem_waddr = cmd.clr_step ? clr_r : where_r;
    mem_wdata = cmd.clr_step ? '0 : {cmd.wr_insert, key_r};
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdq_r <= mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slots_in_use_r <= CFG_SLOTS_RESET;
      clr_r          <= '0;
      occ_r          <= '0;
      pv_r           <= 1'b0;
      hit_r          <= 1'b0;
      div_cnt_r      <= '0;
    end else begin
      if (cfg_wr_en) begin
        slots_in_use_r <= cfg_wr_data;
      end
      if (cmd.clr_step) begin
        clr_r <= clr_r + IW'(1);
      end
      if (cmd.load) begin
        n_r       <= n_eff;
        op_r      <= in_op;
        key_r     <= in_key[KW-1:0];
        ha_r      <= in_hash_primary;
        hb_r      <= in_hash_secondary;
        rem_a_r   <= '0;
        rem_b_r   <= '0;
        div_cnt_r <= '0;
      end else if (cmd.div_step) begin
        ha_r      <= {ha_r[HASH_W-2:0], 1'b0};
        hb_r      <= {hb_r[HASH_W-2:0], 1'b0};
        rem_a_r   <= rem_a_nxt;
        rem_b_r   <= rem_b_nxt;
        div_cnt_r <= div_cnt_r + DIV_CNT_W'(1);
      end
      if (cmd.scan_start) begin
        idx_r  <= IW'(rem_a_r);
        step_r <= IW'(rem_b_r);
        cnt_r  <= '0;
        pv_r   <= 1'b0;
        hit_r  <= 1'b0;
      end else begin
        pv_r <= issue;
        if (issue) begin
          pidx_r <= idx_r;
          idx_r  <= idx_nxt;
          cnt_r  <= cnt_r + NW'(1);
        end
        if (match) begin
          hit_r   <= 1'b1;
          where_r <= pidx_r;
        end
      end
      if (cmd.res_load) begin
        occ_r    <= occ_nxt;
        status_r <= cmd.res_status;
        slot_r   <= cmd.res_slot_en ? SLOT_W'(where_r) : '0;
        count_r  <= COUNT_W'(occ_nxt);
        resize_r <= (free_slots < (n_r >> 2));
      end
    end
  end

  always_comb begin
    st.clr_done  = (clr_r == IW'(MAX_SLOTS - 1));
    st.div_done  = (div_cnt_r == DIV_CNT_W'(HASH_W));
    st.scan_done = hit_r || (!pv_r && (cnt_r == n_r));
    st.hit       = hit_r;
    st.op_insert = (op_r == OP_INSERT);
    st.op_remove = (op_r == OP_REMOVE);
  end

  assign out_status        = status_r;
  assign out_slot_index    = slot_r;
  assign out_entry_count   = count_r;
  assign out_resize_needed = resize_r;

endmodule

`default_nettype wire

@@ hdl/dhot_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module dhot_ctrl
  import dhot_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  wire logic       out_stall,
  input  wire dhot_stat_t st,
  output dhot_cmd_t       cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_SCAN_KEY,
    S_SCAN_FREE,
    S_FINISH
  } state_t;

  state_t  state_r;
  logic    out_valid_r;
  status_t res_status_r;
  logic    res_slot_en_r;
  logic    act_ins_r;
  logic    act_rem_r;

  always_comb begin
    cmd             = '0;
    cmd.res_status  = res_status_r;
    cmd.res_slot_en = res_slot_en_r;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
      end
      S_IDLE: begin
        cmd.load = in_valid;
      end
      S_DIV: begin
        if (st.div_done) begin
          cmd.scan_start = 1'b1;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_SCAN_KEY: begin
        cmd.scan_step  = 1'b1;
        cmd.scan_start = st.scan_done && !st.hit && st.op_insert;
      end
      S_SCAN_FREE: begin
        cmd.scan_step = 1'b1;
        cmd.scan_free = 1'b1;
      end
      S_FINISH: begin
        cmd.res_load  = !out_valid_r || !out_stall;
        cmd.wr_insert = act_ins_r;
        cmd.wr_remove = act_rem_r;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.res_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          if (st.clr_done) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (st.div_done) begin
            state_r <= S_SCAN_KEY;
          end
        end
        S_SCAN_KEY: begin
          if (st.scan_done) begin
            act_ins_r <= 1'b0;
            act_rem_r <= st.hit && st.op_remove;
            if (st.hit) begin
              res_slot_en_r <= 1'b1;
              state_r       <= S_FINISH;
              if (st.op_insert) begin
                res_status_r <= ST_EXISTS;
              end else if (st.op_remove) begin
                res_status_r <= ST_REMOVED;
              end else begin
                res_status_r <= ST_FOUND;
              end
            end else if (st.op_insert) begin
              state_r <= S_SCAN_FREE;
            end else begin
              res_status_r  <= ST_NOT_FOUND;
              res_slot_en_r <= 1'b0;
              state_r       <= S_FINISH;
            end
          end
        end
        S_SCAN_FREE: begin
          if (st.scan_done) begin
            state_r       <= S_FINISH;
            res_slot_en_r <= st.hit;
            act_ins_r     <= st.hit;
            act_rem_r     <= 1'b0;
            res_status_r  <= st.hit ? ST_INSERTED : ST_FULL;
          end
        end
        S_FINISH: begin
          if (cmd.res_load) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

@@ hdl/double_hash_open_table.sv @@
// Open-addressing key table with double hashing.
// Input channel (in_valid / in_stall): one item = op, key and two hashes.
// Result channel (out_valid / out_stall): one result per item with status,
// slot index, entry count after the operation and the resize flag.
// cfg_wr_en / cfg_wr_data set the number of slots probed; write only idle.
// Steps: the item is loaded, both hashes are reduced mod n (one bit per
// cycle), then a key scan runs (one probe per cycle through the registered
// read of the slot memory), stopping early on a match.
// Insert without a match adds a free-slot scan.
// The result register is then written; one item is in work at a time.
// The next item is taken while a result still waits in the output register.
// If out_stall holds that result, a finished item waits until it is taken.
// Reset: the slot memory is swept clear with in_stall high; the size
// register returns to 127 and the entry count to zero.
`timescale 1ns / 1ps
`default_nettype none

module double_hash_open_table
  import dhot_pkg::*;
#(
  parameter int MAX_SLOTS = 128,
  parameter int KEY_WIDTH = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_W-1:0]      cfg_wr_data,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [OP_W-1:0]       in_op,
  input  wire logic [KEY_PORT_W-1:0] in_key,
  input  wire logic [HASH_W-1:0]     in_hash_primary,
  input  wire logic [HASH_W-1:0]     in_hash_secondary,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [STATUS_W-1:0]        out_status,
  output logic [SLOT_W-1:0]          out_slot_index,
  output logic [COUNT_W-1:0]         out_entry_count,
  output logic                       out_resize_needed
);

  dhot_cmd_t  cmd;
  dhot_stat_t st;

  dhot_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .st        (st),
    .cmd       (cmd)
  );

  dhot_dp #(
    .MAX_SLOTS (MAX_SLOTS),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_op             (in_op),
    .in_key            (in_key),
    .in_hash_primary   (in_hash_primary),
    .in_hash_secondary (in_hash_secondary),
    .cmd               (cmd),
    .st                (st),
    .out_status        (out_status),
    .out_slot_index    (out_slot_index),
    .out_entry_count   (out_entry_count),
    .out_resize_needed (out_resize_needed)
  );

endmodule

`default_nettype wire
